@@ rtl/core/cau_pkg.sv @@
// Shared types and default constants for the complex arithmetic unit.
package cau_pkg;

  // Default number format: signed Q16.16.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of every operand and result field on the channels.
  localparam int FIELD_W = 32;

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

endpackage

@@ rtl/core/cau_if.sv @@
// Valid/ready channel interfaces for operands and results.
interface cau_in_if import cau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  func_t                     func;
  logic signed [FIELD_W-1:0] a_real;
  logic signed [FIELD_W-1:0] a_imag;
  logic signed [FIELD_W-1:0] b_real;
  logic signed [FIELD_W-1:0] b_imag;

  modport source (output valid, func, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, func, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if import cau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] res_real;
  logic signed [FIELD_W-1:0] res_imag;
  logic                      overflow;
  logic                      div_zero;

  modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
  modport sink   (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

@@ rtl/core/cau_div.sv @@
// Two-lane pipelined restoring divider: a load stage, then one quotient bit per stage.
module cau_div import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int DW2 = 2 * DATA_WIDTH,
  localparam int NW  = 2 * DATA_WIDTH + 1 + FRAC_BITS,
  localparam int QB  = DATA_WIDTH + 1,
  localparam int RW  = DW2 + 1,
  localparam int CW  = NW + DW2 + QB
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  num_i [2],
  input  logic [DW2-1:0] den_i,
  output logic [QB-1:0]  q_o   [2],
  output logic [DW2-1:0] rem_o [2],
  output logic           big_o [2],
  output logic [DW2-1:0] den_o
);

  logic [DW2-1:0] den_r [QB+1];
  logic [DW2-1:0] rem_r [2][QB+1];
  logic [QB-1:0]  low_r [2][QB+1];
  logic [QB-1:0]  q_r   [2][QB+1];
  logic           big_r [2][QB+1];

  // First stage: flag quotients that cannot fit and load the partial remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den_i;
      for (int l = 0; l < 2; l++) begin
        big_r[l][0] <= CW'(num_i[l]) >= (CW'(den_i) << QB);
        rem_r[l][0] <= DW2'(num_i[l] >> QB);
        low_r[l][0] <= num_i[l][QB-1:0];
        q_r[l][0]   <= '0;
      end
    end
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= QB; k++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RW-1:0] trial;
      logic          ge;

      always_comb begin
        trial = {rem_r[l][k-1], low_r[l][k-1][QB-1]};
        ge    = trial >= {1'b0, den_r[k-1]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[l][k] <= ge ? DW2'(trial - {1'b0, den_r[k-1]}) : DW2'(trial);
          low_r[l][k] <= low_r[l][k-1] << 1;
          q_r[l][k]   <= {q_r[l][k-1][QB-2:0], ge};
          big_r[l][k] <= big_r[l][k-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_r[k-1];
      end
    end
  end

  // Results of the last stage.
  always_comb begin
    den_o = den_r[QB];
    for (int l = 0; l < 2; l++) begin
      q_o[l]   = q_r[l][QB];
      rem_o[l] = rem_r[l][QB];
      big_o[l] = big_r[l][QB];
    end
  end

endmodule

@@ rtl/core/complex_arith_unit.sv @@
// Top level of the pipelined complex add, subtract, multiply and divide unit.
//
// Operands a and b and an operation code arrive on in_if; one result per
// operand set leaves on out_if, in order. Both are valid/ready channels and
// a transfer happens on a clock edge with valid and ready both high.
// Numbers are signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction
// bits (Q16.16 by default). Products and quotients round to nearest with
// ties away from zero; a result out of range saturates and raises
// overflow. A divide by zero returns zero with div_zero set.
// Every operation passes through four arithmetic stages, DATA_WIDTH + 2
// divider stages (one quotient bit per stage after the first) and the
// output register. One transfer is taken every cycle while not stalled.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_if.ready drops; nothing is lost or repeated. A synchronous reset
// on rst_n empties the pipeline and clears out_if.valid.
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_if,
  cau_out_if.source out_if
);

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 2 * W;
  localparam int SW2 = 2 * W + 1;
  localparam int SQ  = SW2 + 1;
  localparam int NW  = 2 * W + 1 + FRAC_BITS;
  localparam int QB  = W + 1;

  // Saturate a sign and magnitude to W bits; the top bit is the overflow flag.
  function automatic logic [W:0] sat_f(input logic neg, input logic [SQ-1:0] q);
    logic [SQ-1:0] lim;
    logic [SQ-1:0] m;
    logic          ovf;
    lim = (SQ'(1) << (W - 1)) - SQ'(!neg);
    ovf = q > lim;
    m   = ovf ? lim : q;
    return {ovf, neg ? W'(-m) : W'(m)};
  endfunction

  logic en;
  logic out_valid_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // Stage 1: operand capture.
  logic                v1_r, v1_nxt;
  func_t               f1_r;
  logic signed [W-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  assign v1_nxt = in_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r  <= in_if.func;
      ar1_r <= W'($unsigned(in_if.a_real));
      ai1_r <= W'($unsigned(in_if.a_imag));
      br1_r <= W'($unsigned(in_if.b_real));
      bi1_r <= W'($unsigned(in_if.b_imag));
    end
  end

  // Stage 2: partial products, squares of the divisor, sums and differences.
  logic                 v2_r;
  func_t                f2_r;
  logic signed [PW-1:0] prr_nxt, pii_nxt, pri_nxt, pir_nxt, sbr_nxt, sbi_nxt;
  logic signed [PW-1:0] prr2_r, pii2_r, pri2_r, pir2_r, sbr2_r, sbi2_r;
  logic signed [W:0]    asr_nxt, asi_nxt, asr2_r, asi2_r;

  always_comb begin
    prr_nxt = ar1_r * br1_r;
    pii_nxt = ai1_r * bi1_r;
    pri_nxt = ar1_r * bi1_r;
    pir_nxt = ai1_r * br1_r;
    sbr_nxt = br1_r * br1_r;
    sbi_nxt = bi1_r * bi1_r;
    if (f1_r == FUNC_SUB) begin
      asr_nxt = (W+1)'(ar1_r) - (W+1)'(br1_r);
      asi_nxt = (W+1)'(ai1_r) - (W+1)'(bi1_r);
    end else begin
      asr_nxt = (W+1)'(ar1_r) + (W+1)'(br1_r);
      asi_nxt = (W+1)'(ai1_r) + (W+1)'(bi1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r   <= f1_r;
      prr2_r <= prr_nxt;
      pii2_r <= pii_nxt;
      pri2_r <= pri_nxt;
      pir2_r <= pir_nxt;
      sbr2_r <= sbr_nxt;
      sbi2_r <= sbi_nxt;
      asr2_r <= asr_nxt;
      asi2_r <= asi_nxt;
    end
  end

  // Stage 3: exact real and imaginary values, and |b|^2.
  logic                  v3_r;
  func_t                 f3_r;
  logic signed [SW2-1:0] sre_nxt, sim_nxt, sre3_r, sim3_r;
  logic [PW-1:0]         den_nxt, den3_r;

  always_comb begin
    den_nxt = $unsigned(sbr2_r) + $unsigned(sbi2_r);
    case (f2_r)
      FUNC_MUL: begin
        sre_nxt = SW2'(prr2_r) - SW2'(pii2_r);
        sim_nxt = SW2'(pri2_r) + SW2'(pir2_r);
      end
      FUNC_DIV: begin
        sre_nxt = SW2'(prr2_r) + SW2'(pii2_r);
        sim_nxt = SW2'(pir2_r) - SW2'(pri2_r);
      end
      default: begin
        sre_nxt = SW2'(asr2_r);
        sim_nxt = SW2'(asi2_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_r   <= f2_r;
      sre3_r <= sre_nxt;
      sim3_r <= sim_nxt;
      den3_r <= den_nxt;
    end
  end

  // Stage 4: sign and magnitude; final results for everything but divide.
  typedef struct packed {
    logic         is_div;
    logic         dz;
    logic         neg_re;
    logic         neg_im;
    logic         ovf;
    logic [W-1:0] res_re;
    logic [W-1:0] res_im;
  } side_t;

  logic          v4_r;
  side_t         side_nxt, side4_r;
  logic [NW-1:0] num_nxt [2];
  logic [NW-1:0] num4_r  [2];
  logic [PW-1:0] den4_r;

  always_comb begin
    logic [SW2-1:0] mag [2];
    logic [SQ-1:0]  t;
    logic [SQ-1:0]  q [2];
    logic [W:0]     s [2];
    logic           neg [2];
    neg[0] = sre3_r[SW2-1];
    neg[1] = sim3_r[SW2-1];
    mag[0] = $unsigned(neg[0] ? -sre3_r : sre3_r);
    mag[1] = $unsigned(neg[1] ? -sim3_r : sim3_r);
    for (int l = 0; l < 2; l++) begin
      t          = {mag[l], 1'b0} >> FRAC_BITS;
      q[l]       = (f3_r == FUNC_MUL) ? (t >> 1) + SQ'(t[0]) : SQ'(mag[l]);
      s[l]       = sat_f(neg[l], q[l]);
      num_nxt[l] = NW'(mag[l]) << FRAC_BITS;
    end
    side_nxt.is_div = f3_r == FUNC_DIV;
    side_nxt.dz     = den3_r == '0;
    side_nxt.neg_re = neg[0];
    side_nxt.neg_im = neg[1];
    side_nxt.ovf    = s[0][W] | s[1][W];
    side_nxt.res_re = s[0][W-1:0];
    side_nxt.res_im = s[1][W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r   <= side_nxt;
      num4_r[0] <= num_nxt[0];
      num4_r[1] <= num_nxt[1];
      den4_r    <= den3_r;
    end
  end

  // Divider stages, with valid bits and side information kept alongside.
  logic [QB-1:0] dq   [2];
  logic [PW-1:0] drem [2];
  logic          dbig [2];
  logic [PW-1:0] dden;
  logic          vd_r   [QB+1];
  side_t         side_r [QB+1];

  cau_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num4_r),
    .den_i (den4_r),
    .q_o   (dq),
    .rem_o (drem),
    .big_o (dbig),
    .den_o (dden)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else if (en) begin
      vd_r[0] <= v4_r;
      for (int k = 1; k <= QB; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side4_r;
      for (int k = 1; k <= QB; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // Output stage: round the quotients, saturate, and pick the result.
  logic signed [FIELD_W-1:0] res_re_nxt, res_im_nxt, res_re_r, res_im_r;
  logic                      ovf_nxt, dz_nxt, ovf_r, dz_r;

  always_comb begin
    side_t          sd;
    logic [SQ-1:0]  qv [2];
    logic [W:0]     s  [2];
    logic           neg [2];
    logic           ru;
    sd     = side_r[QB];
    neg[0] = sd.neg_re;
    neg[1] = sd.neg_im;
    for (int l = 0; l < 2; l++) begin
      ru    = {drem[l], 1'b0} >= {1'b0, dden};
      qv[l] = dbig[l] ? '1 : SQ'(dq[l]) + SQ'(ru);
      s[l]  = sat_f(neg[l], qv[l]);
    end
    if (!sd.is_div) begin
      res_re_nxt = FIELD_W'(signed'(sd.res_re));
      res_im_nxt = FIELD_W'(signed'(sd.res_im));
      ovf_nxt    = sd.ovf;
      dz_nxt     = 1'b0;
    end else if (sd.dz) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      ovf_nxt    = 1'b0;
      dz_nxt     = 1'b1;
    end else begin
      res_re_nxt = FIELD_W'(signed'(s[0][W-1:0]));
      res_im_nxt = FIELD_W'(signed'(s[1][W-1:0]));
      ovf_nxt    = s[0][W] | s[1][W];
      dz_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      ovf_r    <= ovf_nxt;
      dz_r     <= dz_nxt;
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.res_real = res_re_r;
  assign out_if.res_imag = res_im_r;
  assign out_if.overflow = ovf_r;
  assign out_if.div_zero = dz_r;

  // A zero divisor always yields a clean zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && dz_r |-> res_re_r == '0 && res_im_r == '0 && !ovf_r)
    else $error("divide by zero result is not zero");

  // Saturation and divide by zero never flag together.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ovf_r && dz_r))
    else $error("overflow and div_zero both set");

  // A stall freezes the last divider stage, so nothing is lost.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(en) |-> $stable(vd_r[QB]) && $stable(side_r[QB]))
    else $error("pipeline moved during a stall");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the complex arithmetic unit.
`timescale 1ns / 1ps

module testbench;
  import cau_pkg::*;

  localparam int MSG_LIMIT    = 10;
  localparam int RANDOM_ITEMS = 930;
  localparam int QUIET_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [FIELD_W-1:0] re;
    logic [FIELD_W-1:0] im;
    logic               ovf;
    logic               dz;
  } cplx_res_t;

  typedef struct {
    func_t              f;
    logic [FIELD_W-1:0] ar, ai, br, bi;
    bit                 known;
    cplx_res_t          res;
  } vector_t;

  logic clk;
  logic rst_n;
  cau_in_if  in_if ();
  cau_out_if out_if ();

  complex_arith_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  cplx_res_t pending_results[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        quiet;

  // Saturate a sign and magnitude to the 32-bit signed range.
  function automatic logic [FIELD_W-1:0] clamp_q(input bit neg, input logic [127:0] q,
                                                 inout bit ovf);
    logic [127:0] limit;
    logic [127:0] v;
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > limit) begin
      q   = limit;
      ovf = 1'b1;
    end
    v = neg ? -q : q;
    return v[FIELD_W-1:0];
  endfunction

  // Shift an exact value right, rounding to nearest with ties away from zero.
  function automatic logic [FIELD_W-1:0] round_shift(input logic signed [127:0] v,
                                                     input int s, inout bit ovf);
    bit           neg;
    logic [127:0] mag;
    logic [127:0] q;
    neg = v[127];
    mag = neg ? -v : v;
    q   = mag >> s;
    if (s > 0 && mag[s-1]) q = q + 1;
    return clamp_q(neg, q, ovf);
  endfunction

  // Scale by the fraction and divide by the divisor norm, rounded.
  function automatic logic [FIELD_W-1:0] round_quot(input logic signed [127:0] num,
                                                    input logic [127:0] den, inout bit ovf);
    bit           neg;
    logic [127:0] n;
    logic [127:0] q;
    logic [127:0] r;
    neg = num[127];
    n   = neg ? -num : num;
    n   = n << FRAC_BITS_DEF;
    q   = n / den;
    r   = n % den;
    if (r >= den - r) q = q + 1;
    return clamp_q(neg, q, ovf);
  endfunction

  function automatic cplx_res_t complex_result(input func_t f,
      input logic signed [FIELD_W-1:0] ar, ai, br, bi);
    logic signed [127:0] xr, xi, yr, yi;
    logic signed [127:0] den;
    cplx_res_t           r;
    bit                  o;
    xr = ar; xi = ai; yr = br; yi = bi;
    o  = 1'b0;
    r  = '0;
    case (f)
      FUNC_ADD: begin
        r.re = round_shift(xr + yr, 0, o);
        r.im = round_shift(xi + yi, 0, o);
      end
      FUNC_SUB: begin
        r.re = round_shift(xr - yr, 0, o);
        r.im = round_shift(xi - yi, 0, o);
      end
      FUNC_MUL: begin
        r.re = round_shift(xr * yr - xi * yi, FRAC_BITS_DEF, o);
        r.im = round_shift(xr * yi + xi * yr, FRAC_BITS_DEF, o);
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = round_quot(xr * yr + xi * yi, den, o);
          r.im = round_quot(xi * yr - xr * yi, den, o);
        end
      end
    endcase
    r.ovf = o;
    return r;
  endfunction

  // Operand mix: full range, small fixed-point values and the extremes.
  function automatic logic [FIELD_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      5:       return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      6: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: check each transfer and stall the receiver in bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MSG_LIMIT)
            $display("Unexpected result: re=%h im=%h ovf=%b dz=%b", out_if.res_real,
                     out_if.res_imag, out_if.overflow, out_if.div_zero);
        end else begin
          cplx_res_t e;
          e = pending_results.pop_front();
          if (out_if.res_real !== e.re || out_if.res_imag !== e.im ||
              out_if.overflow !== e.ovf || out_if.div_zero !== e.dz) begin
            mismatches <= mismatches + 1;
            if (mismatches < MSG_LIMIT)
              $display("Mismatch: exp re=%h im=%h ovf=%b dz=%b, got re=%h im=%h ovf=%b dz=%b",
                       e.re, e.im, e.ovf, e.dz, out_if.res_real, out_if.res_imag,
                       out_if.overflow, out_if.div_zero);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left   <= $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  // Present one operand set and wait for its transfer.
  task automatic send_operands(input func_t f, input logic [FIELD_W-1:0] ar, ai, br, bi,
                               input bit known, input cplx_res_t res);
    in_if.valid  <= 1'b1;
    in_if.func   <= f;
    in_if.a_real <= ar;
    in_if.a_imag <= ai;
    in_if.b_real <= br;
    in_if.b_imag <= bi;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(known ? res : complex_result(f, ar, ai, br, bi));
  endtask

  // Sender idles between transfers in random bursts.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  vector_t directed[] = '{
    '{FUNC_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b0}},
    '{FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
      '{32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0}},
    '{FUNC_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff, 1'b1,
      '{32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0}},
    '{FUNC_DIV, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0, 1'b1,
      '{32'h0, 32'h0, 1'b0, 1'b1}},
    '{FUNC_DIV, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b1}},
    '{FUNC_MUL, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b1,
      '{32'h0001_0000, 32'h0, 1'b0, 1'b0}},
    '{FUNC_ADD, 32'h1234_5678, 32'hfedc_ba98, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 1'b0, '0},
    '{FUNC_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{FUNC_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '0},
    '{FUNC_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0, 1'b0, '0},
    '{FUNC_MUL, 32'hffff_8000, 32'h0, 32'h0000_0001, 32'h0, 1'b0, '0},
    '{FUNC_MUL, 32'h0000_7fff, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 1'b0, '0},
    '{FUNC_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0, 1'b0, '0},
    '{FUNC_DIV, 32'hfffe_0000, 32'h0, 32'h0003_0000, 32'h0, 1'b0, '0},
    '{FUNC_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0, 1'b0, '0},
    '{FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
    '{FUNC_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0000_0001, 1'b0, '0},
    '{FUNC_DIV, 32'h0000_0001, 32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0},
    '{FUNC_DIV, 32'h0001_8000, 32'h0, 32'h0002_0000, 32'h0002_0000, 1'b0, '0}
  };

  // Main sequence: reset, directed table, random operands, drain.
  initial begin
    func_t f;
    logic [FIELD_W-1:0] ar, ai, br, bi;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.func   <= FUNC_ADD;
    in_if.a_real <= '0;
    in_if.a_imag <= '0;
    in_if.b_real <= '0;
    in_if.b_imag <= '0;
    quiet        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_operands(directed[i].f, directed[i].ar, directed[i].ai, directed[i].br,
                    directed[i].bi, directed[i].known, directed[i].res);
      sender_gap();
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Hold off once until the pipeline has emptied.
      if (n == RANDOM_ITEMS / 2) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      f  = func_t'($urandom_range(0, 3));
      ar = pick_operand();
      ai = pick_operand();
      br = pick_operand();
      bi = pick_operand();
      if (f == FUNC_DIV && $urandom_range(0, 15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_operands(f, ar, ai, br, bi, 1'b0, '0);
      sender_gap();
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ complex_arith_unit.f @@
rtl/core/cau_pkg.sv
rtl/core/cau_if.sv
rtl/core/cau_div.sv
rtl/core/complex_arith_unit.sv
tb/testbench.sv
